/* src/rsa_pkg.sv */
// Shared types and codes for the ring span allocator.
package rsa_pkg;

   localparam int SLOT_W   = 16;
   localparam int RING_W   = 17;
   localparam int VER_W    = 32;
   localparam int STATUS_W = 3;

   typedef enum logic [1:0] {
      OP_ALLOC  = 2'd0,
      OP_RECORD = 2'd1,
      OP_FREE   = 2'd2,
      OP_NONE   = 2'd3
   } opcode_type;

   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_ZERO      = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NO_ROOM   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_BAD_SPAN  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

   typedef struct packed {
      logic [SLOT_W-1:0] start;
      logic [SLOT_W-1:0] count;
      logic [VER_W-1:0]  version;
   } entry_type;

   typedef struct packed {
      logic push;
      logic pop;
   } cell_ctrl_type;

endpackage

/* src/rsa_cell.sv */
// One retire queue cell: loads a new entry or takes its upper neighbor's on a pop.
module rsa_cell (
   input  logic                  clock,
   input  rsa_pkg::cell_ctrl_type ctrl,
   input  logic                  sel,
   input  rsa_pkg::entry_type    new_entry,
   input  rsa_pkg::entry_type    up_entry,
   output rsa_pkg::entry_type    entry
);

   rsa_pkg::entry_type entry_ff, entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.pop) begin
         entry_in = up_entry;
      end else if (ctrl.push && sel) begin
         entry_in = new_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

/* src/ring_span_allocator.sv */
// Top level of the ring span allocator: ring pointers, retire queue chain, control.
// Each transfer is captured in S_IDLE, then allocated or recorded in S_EXEC once
// the output register is free. A free stays in S_EXEC while it releases retired spans,
// since the retire queue, a chain of cells, shifts one entry toward the front per cycle.
// The result goes to an output register so the next request can be captured
// while it waits. A write to csr_wdata empties the ring and the retire queue.
module ring_span_allocator #(
   parameter int MAX_SLOTS    = 65536,
   parameter int RETIRE_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // span_count, span_start, version_tag
   input  logic [1:0]  req_tuser,   // opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // granted_start, granted_count, slots_free, zero pad
   output logic [2:0]  rsp_tuser,   // status
   input  logic        csr_we,
   input  logic [16:0] csr_wdata
);

   localparam int OCC_W = $clog2(RETIRE_DEPTH + 1);
   localparam logic [rsa_pkg::RING_W-1:0] MAX_RING = rsa_pkg::RING_W'(MAX_SLOTS);
   localparam logic [OCC_W-1:0] FULL_OCC = OCC_W'(RETIRE_DEPTH);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } state_type;

   localparam int RW = rsa_pkg::RING_W;

   state_type state_ff, state_in;
   logic [RW-1:0] ring_ff, ring_in, head_ff, head_in, tail_ff, tail_in, free_ff, free_in;
   logic [OCC_W-1:0] occ_ff, occ_in;
   rsa_pkg::opcode_type op_ff, op_in;
   rsa_pkg::entry_type  req_ff, req_in;
   logic rv_ff, rv_in;
   logic [15:0] gs_ff, gs_in, gc_ff, gc_in;
   logic [2:0]  st_ff, st_in;
   logic [RW-1:0] sf_ff, sf_in;

   rsa_pkg::cell_ctrl_type ctrl;
   rsa_pkg::entry_type cells [RETIRE_DEPTH];
   rsa_pkg::entry_type ups   [RETIRE_DEPTH];

   logic [RW-1:0] cnt, right, room, at, sum, clamp;
   logic [RW:0]   fsum;
   logic          fits, out_free, can_pop;

   for (genvar i = 0; i < RETIRE_DEPTH; i++) begin : g_cell
      if (i == RETIRE_DEPTH - 1) begin : g_last
         assign ups[i] = cells[i];
      end else begin : g_mid
         assign ups[i] = cells[i+1];
      end
      rsa_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .sel       (occ_ff == OCC_W'(i)),
         .new_entry (req_ff),
         .up_entry  (ups[i]),
         .entry     (cells[i])
      );
   end

   assign req_tready = (state_ff == S_IDLE);
   assign out_free   = !rv_ff || rsp_tready;
   assign cnt        = {1'b0, req_ff.count};
   assign can_pop    = (occ_ff != '0) && (cells[0].version <= req_ff.version);
   assign clamp      = (csr_wdata < RW'(2)) ? RW'(2) : (csr_wdata > MAX_RING) ? MAX_RING
                       : csr_wdata;

   always_comb begin
      right = ring_ff - tail_ff;
      room  = right - ((head_ff == '0) ? RW'(1) : RW'(0));
      fits  = 1'b0;
      at    = tail_ff;
      if (tail_ff >= head_ff) begin
         if (cnt <= room) begin
            fits = 1'b1;
         end else if (head_ff > RW'(1) && cnt <= head_ff - RW'(1)) begin
            fits = 1'b1;
            at   = '0;
         end
      end else if (cnt <= head_ff - tail_ff - RW'(1)) begin
         fits = 1'b1;
      end
      sum  = at + cnt;
      fsum = {1'b0, free_ff} + {2'b0, cells[0].count};
   end

   always_comb begin
      state_in = state_ff;
      ring_in  = ring_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      free_in  = free_ff;
      occ_in   = occ_ff;
      op_in    = op_ff;
      req_in   = req_ff;
      rv_in    = rv_ff && !rsp_tready;
      gs_in    = gs_ff;
      gc_in    = gc_ff;
      st_in    = st_ff;
      sf_in    = sf_ff;
      ctrl     = '0;
      if (csr_we) begin
         ring_in = clamp;
         head_in = '0;
         tail_in = '0;
         free_in = clamp;
         occ_in  = '0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  op_in    = rsa_pkg::opcode_type'(req_tuser);
                  req_in   = {req_tdata[31:16], req_tdata[15:0], req_tdata[63:32]};
                  state_in = S_EXEC;
               end
            end
            S_EXEC: begin
               if (op_ff == rsa_pkg::OP_FREE && can_pop) begin
                  ctrl.pop = 1'b1;
                  occ_in   = occ_ff - OCC_W'(1);
                  head_in  = ({1'b0, cells[0].start} + {1'b0, cells[0].count} == ring_ff) ? '0
                             : {1'b0, cells[0].start} + {1'b0, cells[0].count};
                  free_in  = (fsum > {1'b0, ring_ff}) ? ring_ff : fsum[RW-1:0];
               end else if (out_free) begin
                  gs_in = '0;
                  gc_in = '0;
                  st_in = rsa_pkg::ST_OK;
                  unique case (op_ff)
                     rsa_pkg::OP_ALLOC: begin
                        if (cnt == '0) begin
                           st_in = rsa_pkg::ST_ZERO;
                        end else if (fits) begin
                           tail_in = (sum == ring_ff) ? '0 : sum;
                           free_in = (free_ff >= cnt) ? free_ff - cnt : '0;
                           gs_in   = at[15:0];
                           gc_in   = req_ff.count;
                        end else begin
                           st_in = rsa_pkg::ST_NO_ROOM;
                        end
                     end
                     rsa_pkg::OP_RECORD: begin
                        if (cnt == '0 || {1'b0, req_ff.start} >= ring_ff ||
                            {1'b0, req_ff.start} + cnt > ring_ff) begin
                           st_in = rsa_pkg::ST_BAD_SPAN;
                        end else if (occ_ff == FULL_OCC) begin
                           st_in = rsa_pkg::ST_FULL;
                        end else begin
                           ctrl.push = 1'b1;
                           occ_in    = occ_ff + OCC_W'(1);
                        end
                     end
                     default: begin
                     end
                  endcase
                  sf_in    = free_in;
                  rv_in    = 1'b1;
                  state_in = S_IDLE;
               end
            end
            default: state_in = S_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ring_ff  <= MAX_RING;
         head_ff  <= '0;
         tail_ff  <= '0;
         free_ff  <= MAX_RING;
         occ_ff   <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         ring_ff  <= ring_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         free_ff  <= free_in;
         occ_ff   <= occ_in;
         rv_ff    <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      req_ff <= req_in;
      gs_ff  <= gs_in;
      gc_ff  <= gc_in;
      st_ff  <= st_in;
      sf_ff  <= sf_in;
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = {7'b0, sf_ff, gc_ff, gs_ff};
   assign rsp_tuser  = st_ff;

endmodule
